// ----- design/owmt_pkg.sv -----
// Shared types and constants of the online weight median tracker.
// Holds the channel word structs, register indexes and sequencer states.
// No dependencies.
`default_nettype none

package owmt_pkg;

	localparam int WEIGHT_W      = 64;
	localparam int LIMIT_W       = 13;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int DEPTH_DEFAULT = 4096;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

	localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_STAKE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LIMIT  = 2'd1;

	typedef struct packed {
		logic [WEIGHT_W-1:0] sample_weight;
	} in_word_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] stake_value;
		logic [WEIGHT_W-1:0] window_median;
		logic [LIMIT_W-1:0]  samples_held;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DROP_WAIT,
		ST_DEL,
		ST_INS,
		ST_INS_LAST,
		ST_SRCH,
		ST_SRCH_WAIT,
		ST_PICK,
		ST_PICK_WAIT,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

// ----- design/owmt_stream_if.sv -----
// Valid/ready channel carrying one word of a given struct type.
// Used for the sample input and the result output of the tracker.
// No dependencies.
`default_nettype none

interface owmt_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/owmt_ram.sv -----
// Simple dual-port memory: one write port, one read port, registered read data.
// Holds the sample ring and the sorted copy of the window.
// No dependencies.
`default_nettype none

module owmt_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/owmt_seq.sv -----
// Sequencer of the median tracker: drops old samples, keeps a sorted copy,
// and picks the median. Drives the ring and sorted-copy memories.
// Depends on owmt_pkg.
`default_nettype none

module owmt_seq #(
	parameter  int DEPTH = owmt_pkg::DEPTH_DEFAULT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [owmt_pkg::WEIGHT_W-1:0]     sample_weight,
	input  wire logic [owmt_pkg::WEIGHT_W-1:0]     minimum_stake,
	input  wire logic [owmt_pkg::LIMIT_W-1:0]      window_limit,
	input  wire logic                              take,
	output logic                                   idle,
	output logic                                   done,
	output owmt_pkg::out_word_t                    result,
	output logic                                   ring_we,
	output logic      [AW-1:0]                     ring_waddr,
	output logic      [owmt_pkg::WEIGHT_W-1:0]     ring_wdata,
	output logic      [AW-1:0]                     ring_raddr,
	input  wire logic [owmt_pkg::WEIGHT_W-1:0]     ring_rdata,
	output logic                                   sort_we,
	output logic      [AW-1:0]                     sort_waddr,
	output logic      [owmt_pkg::WEIGHT_W-1:0]     sort_wdata,
	output logic      [AW-1:0]                     sort_raddr,
	input  wire logic [owmt_pkg::WEIGHT_W-1:0]     sort_rdata
);

	import owmt_pkg::*;

	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int SW = CW + 1;

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [AW-1:0]       ptr_q;
	logic [CW-1:0]       held_q;
	logic [CW-1:0]       lim_q;
	logic [CW-1:0]       a_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       mid_q;
	logic                shift_q;
	logic                rdv_s1;
	logic [AW-1:0]       raddr_s1;
	logic [WEIGHT_W-1:0] x_q;
	logic [WEIGHT_W-1:0] del_q;
	logic [WEIGHT_W-1:0] median_q;

	logic [LW-1:0]       wl_ext;
	logic [CW-1:0]       lim_next;
	logic [SW-1:0]       wp_sum;
	logic [AW-1:0]       wp;
	logic                issue_del;
	logic                issue_ins;
	logic [CW-1:0]       mid;
	logic [CW-1:0]       rank;
	logic [CW-1:0]       pick_addr;
	logic                drop;
	logic                ins_gt;

	// effective limit: zero acts as one, capped at the depth
	always_comb begin
		wl_ext = LW'(window_limit);
		if (wl_ext == '0) begin
			lim_next = CW'(1);
		end else if (wl_ext > LW'(DEPTH)) begin
			lim_next = CW'(DEPTH);
		end else begin
			lim_next = CW'(wl_ext);
		end
	end

	always_comb begin
		wp_sum = SW'(ptr_q) + SW'(held_q);
		if (wp_sum >= SW'(DEPTH)) begin
			wp = AW'(wp_sum - SW'(DEPTH));
		end else begin
			wp = AW'(wp_sum);
		end
	end

	assign drop      = held_q >= lim_q;
	assign issue_del = (state_q == ST_DEL) && (a_q < held_q);
	assign issue_ins = (state_q == ST_INS) && (a_q != '0);
	assign mid       = CW'((SW'(lo_q) + SW'(hi_q)) >> 1);
	assign rank      = CW'((SW'(held_q) + SW'(1)) >> 1);
	assign pick_addr = (rank < lo_q) ? rank : rank - CW'(1);
	assign ins_gt    = sort_rdata > x_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (drop) begin
					state_d = ST_DROP_WAIT;
				end else if (held_q == '0) begin
					state_d = ST_INS_LAST;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_DROP_WAIT: state_d = ST_DEL;
			ST_DEL: begin
				if (a_q == held_q && !rdv_s1) begin
					state_d = ST_CHECK;
				end
			end
			ST_INS: begin
				if (rdv_s1) begin
					if (!ins_gt) begin
						state_d = ST_SRCH;
					end else if (raddr_s1 == '0) begin
						state_d = ST_INS_LAST;
					end
				end
			end
			ST_INS_LAST: state_d = ST_SRCH;
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_SRCH_WAIT;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_SRCH_WAIT: state_d = ST_SRCH;
			ST_PICK: begin
				if (rank == lo_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PICK_WAIT;
				end
			end
			ST_PICK_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ring_we    = (state_q == ST_CHECK) && !drop;
		ring_waddr = wp;
		ring_wdata = x_q;
		ring_raddr = ptr_q;
		sort_we    = 1'b0;
		sort_waddr = '0;
		sort_wdata = x_q;
		sort_raddr = '0;
		case (state_q)
			ST_DEL: begin
				sort_raddr = AW'(a_q);
				if (rdv_s1 && shift_q) begin
					sort_we    = 1'b1;
					sort_waddr = raddr_s1 - AW'(1);
					sort_wdata = sort_rdata;
				end
			end
			ST_INS: begin
				sort_raddr = AW'(a_q - CW'(1));
				if (rdv_s1) begin
					sort_we    = 1'b1;
					sort_waddr = raddr_s1 + AW'(1);
					sort_wdata = ins_gt ? sort_rdata : x_q;
				end
			end
			ST_INS_LAST: begin
				sort_we = 1'b1;
			end
			ST_SRCH:  sort_raddr = AW'(mid);
			ST_PICK:  sort_raddr = AW'(pick_addr);
			default: begin
				sort_raddr = '0;
			end
		endcase
	end

	always_comb begin
		idle                 = state_q == ST_IDLE;
		done                 = state_q == ST_DONE;
		result.window_median = median_q;
		result.stake_value   = (median_q > minimum_stake) ? median_q : minimum_stake;
		result.samples_held  = LIMIT_W'(held_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			held_q  <= '0;
			lim_q   <= CW'(1);
			a_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			shift_q <= 1'b0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= issue_del || issue_ins;
			if (issue_del) begin
				a_q <= a_q + CW'(1);
			end
			if (issue_ins) begin
				a_q <= a_q - CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						lim_q <= lim_next;
					end
				end
				ST_CHECK: begin
					if (!drop) begin
						held_q <= held_q + CW'(1);
						a_q    <= held_q;
						lo_q   <= '0;
						hi_q   <= held_q + CW'(1);
					end
				end
				ST_DROP_WAIT: begin
					ptr_q   <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
					a_q     <= '0;
					shift_q <= 1'b0;
				end
				ST_DEL: begin
					if (rdv_s1 && !shift_q && sort_rdata == del_q) begin
						shift_q <= 1'b1;
					end
					if (a_q == held_q && !rdv_s1) begin
						held_q <= held_q - CW'(1);
					end
				end
				ST_SRCH: begin
					mid_q <= mid;
				end
				ST_SRCH_WAIT: begin
					if (sort_rdata < minimum_stake) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
				end
				default: begin
					shift_q <= shift_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= sort_raddr;
		if (state_q == ST_IDLE && start) begin
			x_q <= sample_weight;
		end
		if (state_q == ST_DROP_WAIT) begin
			del_q <= ring_rdata;
		end
		if (state_q == ST_PICK && rank == lo_q) begin
			median_q <= minimum_stake;
		end
		if (state_q == ST_PICK_WAIT) begin
			median_q <= sort_rdata;
		end
	end

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("held count above depth");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !take) |=> (state_q == ST_DONE && $stable(median_q)))
		else $error("result lost before it was taken");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_sort_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		sort_we |-> (state_q == ST_DEL || state_q == ST_INS || state_q == ST_INS_LAST))
		else $error("sorted copy written outside a pass");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !drop) |=> (held_q == $past(held_q) + CW'(1)))
		else $error("held count not advanced on insert");
`endif

endmodule

`default_nettype wire

// ----- design/online_weight_median_tracker.sv -----
// Online weight median tracker: keeps the latest samples in a ring memory
// and a sorted copy in a second memory; reports the median with the floor
// value as an extra member, and the stake raised to at least the floor.
// Each item walks the sorted copy once to remove the oldest sample when the
// window is full and once to insert the new one, one entry per cycle through
// its single read and write port, then binary-searches it for the floor's
// rank. After window_limit is lowered, every extra sample dropped adds one
// more removal walk. A new word is taken once the previous result sits in
// the output register. No clearing pass after reset.
`default_nettype none

module online_weight_median_tracker #(
	parameter int WINDOW_DEPTH = owmt_pkg::DEPTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	owmt_stream_if.sink                            samples,
	owmt_stream_if.source                          results,
	input  wire logic                              cfg_we,
	input  wire logic [owmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [owmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import owmt_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	logic [WEIGHT_W-1:0] min_stake_q;
	logic [LIMIT_W-1:0]  window_limit_q;
	logic                out_valid_q;
	out_word_t           out_word_q;

	logic                seq_idle;
	logic                seq_done;
	logic                take;
	out_word_t           seq_result;

	logic                ring_we;
	logic [AW-1:0]       ring_waddr;
	logic [WEIGHT_W-1:0] ring_wdata;
	logic [AW-1:0]       ring_raddr;
	logic [WEIGHT_W-1:0] ring_rdata;
	logic                sort_we;
	logic [AW-1:0]       sort_waddr;
	logic [WEIGHT_W-1:0] sort_wdata;
	logic [AW-1:0]       sort_raddr;
	logic [WEIGHT_W-1:0] sort_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_stake_q    <= '0;
			window_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MINIMUM_STAKE: min_stake_q    <= cfg_data[WEIGHT_W-1:0];
				REG_WINDOW_LIMIT:  window_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
					min_stake_q <= min_stake_q;
				end
			endcase
		end
	end

	assign take = seq_done && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_word_q <= seq_result;
		end
	end

	assign samples.ready   = seq_idle;
	assign results.valid   = out_valid_q;
	assign results.payload = out_word_q;

	owmt_seq #(
		.DEPTH (WINDOW_DEPTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (samples.valid && seq_idle),
		.sample_weight (samples.payload.sample_weight),
		.minimum_stake (min_stake_q),
		.window_limit  (window_limit_q),
		.take          (take),
		.idle          (seq_idle),
		.done          (seq_done),
		.result        (seq_result),
		.ring_we       (ring_we),
		.ring_waddr    (ring_waddr),
		.ring_wdata    (ring_wdata),
		.ring_raddr    (ring_raddr),
		.ring_rdata    (ring_rdata),
		.sort_we       (sort_we),
		.sort_waddr    (sort_waddr),
		.sort_wdata    (sort_wdata),
		.sort_raddr    (sort_raddr),
		.sort_rdata    (sort_rdata)
	);

	owmt_ram #(
		.DATA_W (WEIGHT_W),
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (AW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	owmt_ram #(
		.DATA_W (WEIGHT_W),
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (AW)
	) u_sorted (
		.clk   (clk),
		.we    (sort_we),
		.waddr (sort_waddr),
		.wdata (sort_wdata),
		.raddr (sort_raddr),
		.rdata (sort_rdata)
	);

endmodule

`default_nettype wire

// ----- verif/owmt_median_checker.sv -----
// Checker for the online weight median tracker: watches the sample and result
// channels and the register port, predicts each result and compares it.
// Depends on owmt_pkg and owmt_stream_if.
`timescale 1ns / 1ps

module owmt_median_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	owmt_stream_if                           samples,
	owmt_stream_if                           results,
	input  logic                             cfg_we,
	input  logic [owmt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [owmt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               awaiting
);

	import owmt_pkg::*;

	localparam int DEPTH  = DEPTH_DEFAULT;
	localparam int SLOT_W = $clog2(DEPTH);

	logic [WEIGHT_W-1:0] floor_weight;
	logic [LIMIT_W-1:0]  limit_reg;
	logic [WEIGHT_W-1:0] window_ring [DEPTH];
	int unsigned         oldest_slot;
	int unsigned         held;
	out_word_t           stake_queue [$];

	function automatic out_word_t predict_stake(input logic [WEIGHT_W-1:0] weight);
		int unsigned         lim;
		logic [WEIGHT_W-1:0] members [$];
		out_word_t           r;
		lim = 32'(limit_reg);
		if (lim == 0)
			lim = 1;
		if (lim > DEPTH)
			lim = DEPTH;
		while (held >= lim && held > 0) begin
			oldest_slot = (oldest_slot + 1) % DEPTH;
			held--;
		end
		window_ring[SLOT_W'((oldest_slot + held) % DEPTH)] = weight;
		held++;
		members = {floor_weight};
		for (int unsigned i = 0; i < held; i++)
			members = {members, window_ring[SLOT_W'((oldest_slot + i) % DEPTH)]};
		members.sort();
		r.window_median = members[(held + 1) / 2];
		r.stake_value   = (r.window_median > floor_weight) ? r.window_median : floor_weight;
		r.samples_held  = held[LIMIT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [WEIGHT_W-1:0] want,
			input logic [WEIGHT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t got;
		if (!arst_n) begin
			floor_weight = '0;
			limit_reg    = LIMIT_RESET;
			oldest_slot  = 0;
			held         = 0;
			mismatches   = 0;
			stake_queue.delete();
			awaiting <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MINIMUM_STAKE)
					floor_weight = cfg_data[WEIGHT_W-1:0];
				else if (cfg_index == REG_WINDOW_LIMIT)
					limit_reg = cfg_data[LIMIT_W-1:0];
			end
			if (results.valid && results.ready) begin
				got = results.payload;
				if (stake_queue.size() == 0) begin
					$display("%0t: result word expected none got %h", $time, got);
					mismatches++;
				end else begin
					want = stake_queue.pop_front();
					check_field("stake_value", want.stake_value, got.stake_value);
					check_field("window_median", want.window_median, got.window_median);
					check_field("samples_held", 64'(want.samples_held),
						64'(got.samples_held));
				end
			end
			if (samples.valid && samples.ready)
				stake_queue = {stake_queue, predict_stake(samples.payload)};
			awaiting <= stake_queue.size();
		end
	end

endmodule

// ----- verif/online_weight_median_tracker_test.sv -----
// Top of the median tracker testbench: clock, reset, sample and register
// stimulus, random stalls on both channels, watchdog and verdict.
// Depends on owmt_pkg, owmt_stream_if, the tracker and owmt_median_checker.
`timescale 1ns / 1ps

module online_weight_median_tracker_test;
	import owmt_pkg::*;

	localparam int STALL_LIMIT = 100_000;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [WEIGHT_W-1:0] ALL_ONES = '1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic [WEIGHT_W-1:0]    cur_floor = '0;
	logic                   steady = 1'b0;
	int                     mismatches;
	int                     awaiting;
	int                     stall_cycles = 0;

	owmt_stream_if #(.word_t(in_word_t))  sample_ch ();
	owmt_stream_if #(.word_t(out_word_t)) result_ch ();

	online_weight_median_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	owmt_median_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (sample_ch),
		.results    (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= steady || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic offer_sample(input logic [WEIGHT_W-1:0] weight);
		in_word_t word;
		word.sample_weight = weight;
		if (!steady && $urandom_range(99) < 24) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.payload <= word;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (index == REG_MINIMUM_STAKE)
			cur_floor = data;
	endtask

	function automatic logic [WEIGHT_W-1:0] draw_weight();
		logic [WEIGHT_W-1:0] w;
		case ($urandom_range(3))
			0: w = {$urandom, $urandom};
			1: w = 64'($urandom_range(15));
			2: w = cur_floor + 64'($urandom_range(6)) - 64'd3;
			default: w = {32'hFFFF_FFFF - 32'($urandom_range(3)), $urandom};
		endcase
		return w;
	endfunction

	task automatic run_random(input int count);
		repeat (count) offer_sample(draw_weight());
		drain_results();
	endtask

	initial begin
		sample_ch.valid   = 1'b0;
		sample_ch.payload = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_sample('0);
		offer_sample(ALL_ONES);
		offer_sample(64'd1);
		offer_sample(64'h8000_0000_0000_0000);
		offer_sample(64'h7FFF_FFFF_FFFF_FFFF);
		drain_results();

		write_reg(REG_MINIMUM_STAKE, ALL_ONES);
		write_reg(REG_WINDOW_LIMIT, 64'd3);
		offer_sample(64'd10);
		offer_sample(ALL_ONES);
		offer_sample('0);
		drain_results();

		write_reg(REG_SPARE_LO, ALL_ONES);
		write_reg(REG_SPARE_HI, ALL_ONES);
		write_reg(REG_WINDOW_LIMIT, 64'h2000);
		write_reg(REG_MINIMUM_STAKE, 64'h5555_5555_5555_5555);
		offer_sample(64'h5555_5555_5555_5554);
		offer_sample(64'hAAAA_AAAA_AAAA_AAAA);
		offer_sample(64'h5555_5555_5555_5555);
		drain_results();

		write_reg(REG_WINDOW_LIMIT, 64'd1);
		offer_sample(64'd7);
		offer_sample('0);
		drain_results();

		write_reg(REG_WINDOW_LIMIT, 64'h1FFF);
		write_reg(REG_MINIMUM_STAKE, 64'd1);
		offer_sample(64'd1);
		offer_sample('0);
		offer_sample(64'd2);
		offer_sample(ALL_ONES);
		offer_sample(64'd1);
		drain_results();

		write_reg(REG_MINIMUM_STAKE, {$urandom, $urandom});
		write_reg(REG_WINDOW_LIMIT, 64'd4096);
		run_random(40);

		steady = 1'b1;
		write_reg(REG_WINDOW_LIMIT, 64'd7);
		run_random(25);
		steady = 1'b0;

		write_reg(REG_MINIMUM_STAKE, '0);
		repeat (4) begin
			write_reg(REG_WINDOW_LIMIT, 64'($urandom_range(1, 12)));
			run_random(5);
		end

		write_reg(REG_MINIMUM_STAKE, 64'($urandom_range(20)));
		write_reg(REG_WINDOW_LIMIT, 64'd4096);
		run_random(15);

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
